@@ src/imatc_pkg.sv @@
// Package for the integer median and area triangle check unit.
// Holds the width constants, derived sizes and the verdict codes.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package imatc_pkg;

    // Width of one side length.
    localparam int SIDE_BITS = 24;

    // Stream widths: three sides in, one verdict out, padded to bytes.
    localparam int S_TDATA_W = ((3 * SIDE_BITS + 7) / 8) * 8;
    localparam int VERD_W    = 2;
    localparam int M_TDATA_W = ((VERD_W + 7) / 8) * 8;

    // Median arithmetic: squares, sum of two squares, doubled sum.
    localparam int SQ_W   = 2 * SIDE_BITS;
    localparam int SUM_W  = SQ_W + 1;
    localparam int DIFF_W = SQ_W + 2;

    // Heron product: perimeter times three positive differences.
    localparam int FAC_W  = SIDE_BITS + 1;
    localparam int PER_W  = SIDE_BITS + 2;
    localparam int PROD_W = 4 * SIDE_BITS + 5;

    // Chunked multiply of the running product by one factor.
    localparam int CH_W  = SIDE_BITS;
    localparam int NCH   = (PROD_W + CH_W - 1) / CH_W;
    localparam int SRC_W = NCH * CH_W;
    localparam int CC_W  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int MUL_W = CH_W + FAC_W;

    // Bit-serial square root, sized for the Heron quotient.
    localparam int ROOT_W = 2 * SIDE_BITS + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int IT_W   = $clog2(ROOT_W + 1);

    typedef enum logic [VERD_W-1:0] {
        VERD_NOT_TRI = 2'd0,
        VERD_NO_MED  = 2'd1,
        VERD_NO_AREA = 2'd2,
        VERD_BOTH    = 2'd3
    } verdict_t;

endpackage

`default_nettype wire

@@ src/integer_median_area_triangle_check_unit.sv @@
// Top level of the integer median and area triangle check unit; depends on imatc_pkg.
// An accepted input beat first takes the triangle test; a triangle then takes the three median
// tests and the area test, stopping at the first that fails. The root step unit works out one
// root bit per cycle, SIDE_BITS per median, 2*SIDE_BITS+1 for the area.
// The unit takes no new item while one is in work; s_tready
// returns once the result sits in the output register. Reset: synchronous, active low.
`timescale 1ns / 1ps
`default_nettype none

// One shared multiplier and one shared root step unit run under a sequencer.
// Reset empties the output register and returns the sequencer to idle.
module integer_median_area_triangle_check_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input channel.
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // From bit 0 up: side_a, side_b, side_c.
    input  wire logic [imatc_pkg::S_TDATA_W-1:0] s_tdata,
    // Result channel.
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // From bit 0 up: verdict, then zero padding.
    output      logic [imatc_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int SB = imatc_pkg::SIDE_BITS;

    // One-hot sequencer states.
    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_TRI   = 12'b0000_0000_0010,
        ST_SQ    = 12'b0000_0000_0100,
        ST_MSUM  = 12'b0000_0000_1000,
        ST_MDIFF = 12'b0000_0001_0000,
        ST_HMUL  = 12'b0000_0010_0000,
        ST_HACC  = 12'b0000_0100_0000,
        ST_HNEXT = 12'b0000_1000_0000,
        ST_HCHK  = 12'b0001_0000_0000,
        ST_ROOT  = 12'b0010_0000_0000,
        ST_RCHK  = 12'b0100_0000_0000,
        ST_FIN   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Sides rotate through side0 during squaring, returning to a, b, c.
    logic [SB-1:0] side0_reg, side0_next;
    logic [SB-1:0] side1_reg, side1_next;
    logic [SB-1:0] side2_reg, side2_next;

    // Squares; sq0 is always the side whose median is under test.
    logic [imatc_pkg::SQ_W-1:0]  sq0_reg, sq0_next;
    logic [imatc_pkg::SQ_W-1:0]  sq1_reg, sq1_next;
    logic [imatc_pkg::SQ_W-1:0]  sq2_reg, sq2_next;
    logic [imatc_pkg::SUM_W-1:0] sum_reg, sum_next;

    // Heron factors (b+c-a, a+c-b, a+b-c), consumed from fac0.
    logic [imatc_pkg::FAC_W-1:0] fac0_reg, fac0_next;
    logic [imatc_pkg::FAC_W-1:0] fac1_reg, fac1_next;
    logic [imatc_pkg::FAC_W-1:0] fac2_reg, fac2_next;

    // Running product: src is shifted out a chunk at a time from the top,
    // acc collects the new product in Horner order.
    logic [imatc_pkg::SRC_W-1:0]  src_reg, src_next;
    logic [imatc_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic [imatc_pkg::MUL_W-1:0]  mul_reg, mul_next;

    // Root step unit.
    logic [imatc_pkg::RAD_W-1:0]  rad_reg, rad_next;
    logic [imatc_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [imatc_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [imatc_pkg::IT_W-1:0]   iter_reg, iter_next;

    // Median index, squaring step or Heron pass; chunk count within a pass.
    logic [1:0]                 cnt_reg, cnt_next;
    logic [imatc_pkg::CC_W-1:0] cc_reg, cc_next;
    logic                       heron_reg, heron_next;

    imatc_pkg::verdict_t verd_reg, verd_next;

    // Output register.
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [imatc_pkg::VERD_W-1:0]  m_verd_reg, m_verd_next;

    // Shared multiplier.
    logic [imatc_pkg::CH_W-1:0]  mul_a;
    logic [imatc_pkg::FAC_W-1:0] mul_b;
    logic [imatc_pkg::MUL_W-1:0] mul_full;

    // Triangle test terms.
    logic [imatc_pkg::FAC_W-1:0] sum_ab, sum_ac, sum_bc;
    logic [imatc_pkg::PER_W-1:0] perim;
    logic                        not_tri;

    // Median quantity.
    logic [imatc_pkg::DIFF_W-1:0] med_pos, med_neg, med_diff;

    // Root step.
    logic [imatc_pkg::REM_W-1:0]  rem_sh, trial;
    logic                         take;

    logic [imatc_pkg::PROD_W-1:0] prod;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(imatc_pkg::M_TDATA_W - imatc_pkg::VERD_W){1'b0}}, m_verd_reg};

    // The multiplier squares a side while squaring and multiplies the top
    // chunk of the running product by the current factor otherwise.
    always_comb begin
        if (state_reg == ST_SQ) begin
            mul_a = side0_reg;
            mul_b = {1'b0, side0_reg};
        end else begin
            mul_a = src_reg[imatc_pkg::SRC_W-1 -: imatc_pkg::CH_W];
            mul_b = fac0_reg;
        end
    end

    assign mul_full = imatc_pkg::MUL_W'(mul_a) * imatc_pkg::MUL_W'(mul_b);

    assign sum_ab  = {1'b0, side0_reg} + {1'b0, side1_reg};
    assign sum_ac  = {1'b0, side0_reg} + {1'b0, side2_reg};
    assign sum_bc  = {1'b0, side1_reg} + {1'b0, side2_reg};
    assign perim   = {1'b0, sum_ab} + imatc_pkg::PER_W'(side2_reg);
    assign not_tri = (sum_ab <= {1'b0, side2_reg}) || (sum_ac <= {1'b0, side1_reg}) ||
                     (sum_bc <= {1'b0, side0_reg});

    // 2(y^2 + z^2) - x^2, valid when med_pos is strictly larger.
    assign med_pos  = {sum_reg, 1'b0};
    assign med_neg  = {2'b00, sq0_reg};
    assign med_diff = med_pos - med_neg;

    // Restoring square root: bring down two radicand bits, try 4*root+1.
    assign rem_sh = {rem_reg[imatc_pkg::REM_W-3:0], rad_reg[imatc_pkg::RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    assign prod = src_reg[imatc_pkg::PROD_W-1:0];

    always_comb begin
        state_next    = state_reg;
        side0_next    = side0_reg;
        side1_next    = side1_reg;
        side2_next    = side2_reg;
        sq0_next      = sq0_reg;
        sq1_next      = sq1_reg;
        sq2_next      = sq2_reg;
        sum_next      = sum_reg;
        fac0_next     = fac0_reg;
        fac1_next     = fac1_reg;
        fac2_next     = fac2_reg;
        src_next      = src_reg;
        acc_next      = acc_reg;
        mul_next      = mul_reg;
        rad_next      = rad_reg;
        root_next     = root_reg;
        rem_next      = rem_reg;
        iter_next     = iter_reg;
        cnt_next      = cnt_reg;
        cc_next       = cc_reg;
        heron_next    = heron_reg;
        verd_next     = verd_reg;
        m_verd_next   = m_verd_reg;
        m_tvalid_next = m_tvalid_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    side0_next = s_tdata[SB-1:0];
                    side1_next = s_tdata[2*SB-1:SB];
                    side2_next = s_tdata[3*SB-1:2*SB];
                    state_next = ST_TRI;
                end
            end
            ST_TRI: begin
                if (not_tri) begin
                    verd_next  = imatc_pkg::VERD_NOT_TRI;
                    state_next = ST_FIN;
                end else begin
                    src_next   = {{(imatc_pkg::SRC_W - imatc_pkg::PER_W){1'b0}}, perim};
                    fac0_next  = sum_bc - {1'b0, side0_reg};
                    fac1_next  = sum_ac - {1'b0, side1_reg};
                    fac2_next  = sum_ab - {1'b0, side2_reg};
                    cnt_next   = 2'd0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                sq2_next   = mul_full[imatc_pkg::SQ_W-1:0];
                sq1_next   = sq2_reg;
                sq0_next   = sq1_reg;
                side0_next = side1_reg;
                side1_next = side2_reg;
                side2_next = side0_reg;
                if (cnt_reg == 2'd2) begin
                    cnt_next   = 2'd0;
                    state_next = ST_MSUM;
                end else begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            ST_MSUM: begin
                sum_next   = {1'b0, sq1_reg} + {1'b0, sq2_reg};
                state_next = ST_MDIFF;
            end
            ST_MDIFF: begin
                if ((med_pos > med_neg) && (med_diff[1:0] == 2'b00)) begin
                    // The quarter has 2*SIDE_BITS bits; left-align it so
                    // SIDE_BITS steps finish the root.
                    rad_next   = {med_diff[imatc_pkg::DIFF_W-1:2],
                                  {(imatc_pkg::RAD_W - imatc_pkg::SQ_W){1'b0}}};
                    root_next  = '0;
                    rem_next   = '0;
                    iter_next  = imatc_pkg::IT_W'(SB);
                    heron_next = 1'b0;
                    state_next = ST_ROOT;
                end else begin
                    verd_next  = imatc_pkg::VERD_NO_MED;
                    state_next = ST_FIN;
                end
            end
            ST_HMUL: begin
                mul_next   = mul_full;
                src_next   = {src_reg[imatc_pkg::SRC_W-imatc_pkg::CH_W-1:0],
                              {imatc_pkg::CH_W{1'b0}}};
                state_next = ST_HACC;
            end
            ST_HACC: begin
                acc_next = {acc_reg[imatc_pkg::PROD_W-imatc_pkg::CH_W-1:0],
                            {imatc_pkg::CH_W{1'b0}}} + imatc_pkg::PROD_W'(mul_reg);
                if (cc_reg == imatc_pkg::CC_W'(imatc_pkg::NCH - 1)) begin
                    cc_next    = '0;
                    state_next = ST_HNEXT;
                end else begin
                    cc_next    = cc_reg + imatc_pkg::CC_W'(1);
                    state_next = ST_HMUL;
                end
            end
            ST_HNEXT: begin
                src_next  = {{(imatc_pkg::SRC_W - imatc_pkg::PROD_W){1'b0}}, acc_reg};
                acc_next  = '0;
                fac0_next = fac1_reg;
                fac1_next = fac2_reg;
                if (cnt_reg == 2'd2) begin
                    cnt_next   = 2'd0;
                    state_next = ST_HCHK;
                end else begin
                    cnt_next   = cnt_reg + 2'd1;
                    state_next = ST_HMUL;
                end
            end
            ST_HCHK: begin
                if ((prod == '0) || (prod[3:0] != 4'h0)) begin
                    verd_next  = imatc_pkg::VERD_NO_AREA;
                    state_next = ST_FIN;
                end else begin
                    rad_next   = {{(imatc_pkg::RAD_W - imatc_pkg::PROD_W + 4){1'b0}},
                                  prod[imatc_pkg::PROD_W-1:4]};
                    root_next  = '0;
                    rem_next   = '0;
                    iter_next  = imatc_pkg::IT_W'(imatc_pkg::ROOT_W);
                    heron_next = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                rad_next = {rad_reg[imatc_pkg::RAD_W-3:0], 2'b00};
                if (take) begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[imatc_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[imatc_pkg::ROOT_W-2:0], 1'b0};
                end
                iter_next = iter_reg - imatc_pkg::IT_W'(1);
                if (iter_reg == imatc_pkg::IT_W'(1)) begin
                    state_next = ST_RCHK;
                end
            end
            ST_RCHK: begin
                if (rem_reg != '0) begin
                    verd_next  = heron_reg ? imatc_pkg::VERD_NO_AREA : imatc_pkg::VERD_NO_MED;
                    state_next = ST_FIN;
                end else if (heron_reg) begin
                    verd_next  = imatc_pkg::VERD_BOTH;
                    state_next = ST_FIN;
                end else begin
                    // Rotate so the next side's square sits in sq0.
                    sq0_next = sq1_reg;
                    sq1_next = sq2_reg;
                    sq2_next = sq0_reg;
                    if (cnt_reg == 2'd2) begin
                        cnt_next   = 2'd0;
                        cc_next    = '0;
                        acc_next   = '0;
                        state_next = ST_HMUL;
                    end else begin
                        cnt_next   = cnt_reg + 2'd1;
                        state_next = ST_MSUM;
                    end
                end
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_verd_next   = verd_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        side0_reg  <= side0_next;
        side1_reg  <= side1_next;
        side2_reg  <= side2_next;
        sq0_reg    <= sq0_next;
        sq1_reg    <= sq1_next;
        sq2_reg    <= sq2_next;
        sum_reg    <= sum_next;
        fac0_reg   <= fac0_next;
        fac1_reg   <= fac1_next;
        fac2_reg   <= fac2_next;
        src_reg    <= src_next;
        acc_reg    <= acc_next;
        mul_reg    <= mul_next;
        rad_reg    <= rad_next;
        root_reg   <= root_next;
        rem_reg    <= rem_next;
        iter_reg   <= iter_next;
        cnt_reg    <= cnt_next;
        cc_reg     <= cc_next;
        heron_reg  <= heron_next;
        verd_reg   <= verd_next;
        m_verd_reg <= m_verd_next;
    end

endmodule

`default_nettype wire

@@ src/imatc_checker.sv @@
// Port-level checker for the integer median and area triangle check unit.
// Depends on imatc_pkg; bound to the top level by the bind at the end.
`timescale 1ns / 1ps
`default_nettype none

module imatc_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [imatc_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [imatc_pkg::M_TDATA_W-1:0] m_tdata
);

    // Items accepted but not yet delivered.
    logic [1:0] pend_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'd0;
        end else begin
            pend_reg <= pend_reg + {1'b0, in_beat} - {1'b0, out_beat};
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> !s_tready)
        else $error("input taken while an item is in work");

    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result beat without a matching input beat");

    a_ready_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> pend_reg <= 2'd1)
        else $error("ready with more than one item outstanding");

endmodule

bind integer_median_area_triangle_check_unit imatc_checker u_imatc_checker (.*);

`default_nettype wire
